// ===== rtl/ovs_pkg.sv =====
// ----------------------------------------------------------------------------
// ovs_pkg
// Shared constants, types and tables for the obstacle velocity scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ovs_pkg;

  localparam int MAX_SENSORS  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int SLOT_W       = $clog2(MAX_SENSORS);
  localparam int ADDR_W       = $clog2(2 * MAX_SENSORS);
  localparam int CNT_W        = $clog2(MAX_SENSORS + 1);
  localparam int DEPTH        = 2 * MAX_SENSORS;
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = 31;
  localparam int ONE_Q15      = 32768;
  localparam int QUARTER      = 16384;
  localparam logic signed [33:0] COS_GAIN = 34'sd652032874;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_VEL   = 2'd2;

  localparam logic [1:0] REG_STOP = 2'd0;
  localparam logic [1:0] REG_SLOW = 2'd1;

  typedef struct packed {
    logic [15:0]        range;
    logic signed [15:0] bearing;
    logic               finite;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            ent;
  } wr_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic               have;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [13:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [13:0] t;
    case (i)
      5'd0:  t = 14'd8192;
      5'd1:  t = 14'd4836;
      5'd2:  t = 14'd2555;
      5'd3:  t = 14'd1297;
      5'd4:  t = 14'd651;
      5'd5:  t = 14'd326;
      5'd6:  t = 14'd163;
      5'd7:  t = 14'd81;
      5'd8:  t = 14'd41;
      5'd9:  t = 14'd20;
      5'd10: t = 14'd10;
      5'd11: t = 14'd5;
      5'd12: t = 14'd3;
      5'd13: t = 14'd1;
      5'd14: t = 14'd1;
      default: t = 14'd0;
    endcase
    return t;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic bank,
                                                  input logic [CNT_W-1:0] k);
    logic [ADDR_W:0] a;
    a = (bank ? (ADDR_W+1)'(MAX_SENSORS) : '0) + (ADDR_W+1)'(k);
    return a[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ovs_ifs.sv =====
// ----------------------------------------------------------------------------
// ovs_ifs
// Handshake channels of the obstacle velocity scaler.
// ----------------------------------------------------------------------------
`default_nettype none

interface ovs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        distance;
  logic signed [15:0] direction;
  logic               reading_valid;
  logic               last_reading;
  logic signed [15:0] velocity_x;
  logic signed [15:0] velocity_y;
  modport source (output valid, action, distance, direction, reading_valid,
                  last_reading, velocity_x, velocity_y, input ready);
  modport sink   (input valid, action, distance, direction, reading_valid,
                  last_reading, velocity_x, velocity_y, output ready);
endinterface

interface ovs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled_x;
  logic signed [15:0] scaled_y;
  logic [15:0]        applied_scale;
  logic               data_present;
  modport source (output valid, scaled_x, scaled_y, applied_scale, data_present,
                  input ready);
  modport sink   (input valid, scaled_x, scaled_y, applied_scale, data_present,
                  output ready);
endinterface

interface ovs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/obstacle_velocity_scaler_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_velocity_scaler_core
// Scales a planar velocity command by the nearest obstacle ahead.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries items: sensor readings, clear, velocity commands.
//   out_o returns one result per velocity command, in order.
//   cfg_i writes stop_distance (index 0) and slow_distance (index 1).
// Readings and clears are never held, but a reading that ends a frame is
// held until every queued command has finished with the active bank.
// Commands wait in a two-entry queue. A command with no frame or zero
// velocity goes straight to scaling; otherwise the 16-step heading CORDIC
// runs, the readings of the frame are walked, and each reading in the cone
// runs a 31-step loop with the cosine CORDIC and the one-bit-per-cycle ratio
// divider together.
// The result sits in an output register; a stalled receiver holds it and the
// back end waits, while the queue keeps taking commands until full.
// Reset sets the registers to 300 and 1000, drops any frame and empties the
// queue; the store contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_velocity_scaler_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ovs_in_if.sink    in_i,
  ovs_cfg_if.sink   cfg_i,
  ovs_out_if.source out_o
);

  ovs_pkg::wr_t        wr;
  ovs_pkg::cmd_t       q_cmd;
  ovs_pkg::back_stat_t stat;
  logic                q_valid, q_pop;

  ovs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .stat_i    (stat),
    .wr_o      (wr),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  ovs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .wr_i      (wr),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .stat_o    (stat),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ovs_front.sv =====
// ----------------------------------------------------------------------------
// ovs_front
// Accepts items, fills the inactive bank, swaps banks and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  ovs_in_if.sink                  in_i,
  input  wire ovs_pkg::back_stat_t stat_i,
  output ovs_pkg::wr_t            wr_o,
  output logic                    q_valid_o,
  output ovs_pkg::cmd_t           q_cmd_o,
  input  wire logic               q_pop_i
);

  logic [ovs_pkg::CNT_W-1:0] fill_q, fill_d, count_q, count_d;
  logic                      bank_q, bank_d, have_q, have_d;
  ovs_pkg::cmd_t             fifo_q [2];
  logic                      rd_ptr_q, wr_ptr_q;
  logic [1:0]                used_q;
  logic                      accept, push, room, swap;
  logic [ovs_pkg::CNT_W-1:0] fill_inc;

  assign swap = (in_i.action == ovs_pkg::ACT_READ) && in_i.last_reading;
  assign room = (used_q != 2'd2);

  always_comb begin
    in_i.ready = 1'b1;
    if (in_i.action == ovs_pkg::ACT_VEL) begin
      in_i.ready = room;
    end else if (swap) begin
      // hold a bank swap until no command still reads the active bank
      in_i.ready = (used_q == 2'd0) && !stat_i.busy;
    end
  end

  assign accept = in_i.valid && in_i.ready;
  assign push   = accept && (in_i.action == ovs_pkg::ACT_VEL);

  always_comb begin
    fill_d   = fill_q;
    count_d  = count_q;
    bank_d   = bank_q;
    have_d   = have_q;
    fill_inc = fill_q;
    wr_o.en  = 1'b0;
    wr_o.addr = ovs_pkg::slot_addr(!bank_q, fill_q);
    wr_o.ent.range   = in_i.distance;
    wr_o.ent.bearing = in_i.direction;
    wr_o.ent.finite  = in_i.reading_valid;
    if (accept && (in_i.action == ovs_pkg::ACT_READ)) begin
      if (fill_q < ovs_pkg::CNT_W'(ovs_pkg::MAX_SENSORS)) begin
        wr_o.en  = 1'b1;
        fill_inc = fill_q + 1'b1;
      end
      fill_d = fill_inc;
      if (in_i.last_reading) begin
        bank_d  = !bank_q;
        count_d = fill_inc;
        have_d  = (fill_inc != '0);
        fill_d  = '0;
      end
    end else if (accept && (in_i.action == ovs_pkg::ACT_CLEAR)) begin
      have_d = 1'b0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      count_q  <= '0;
      bank_q   <= 1'b0;
      have_q   <= 1'b0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      bank_q  <= bank_d;
      have_q  <= have_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      used_q <= used_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{vx: in_i.velocity_x, vy: in_i.velocity_y,
                            bank: bank_q, count: count_q, have: have_q};
    end
  end

  assign q_valid_o = (used_q != 2'd0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/ovs_back.sv =====
// ----------------------------------------------------------------------------
// ovs_back
// Holds the reading store and runs heading, walk, cosine, ratio and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ovs_cfg_if.sink       cfg_i,
  input  wire ovs_pkg::wr_t wr_i,
  input  wire logic     q_valid_i,
  input  wire ovs_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output ovs_pkg::back_stat_t stat_o,
  ovs_out_if.source     out_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HEAD  = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_CHECK = 10'b0000001000,
    S_ITER  = 10'b0000010000,
    S_ALIGN = 10'b0000100000,
    S_SCALE = 10'b0001000000,
    S_NEXT  = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_ROUND = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  ovs_pkg::entry_t mem [ovs_pkg::DEPTH];
  ovs_pkg::entry_t rd_q;

  logic [15:0] stop_q, slow_q;
  ovs_pkg::cmd_t cmd_q;
  logic [ovs_pkg::CNT_W-1:0] k_q;
  logic [ovs_pkg::STEP_W-1:0] it_q;
  logic signed [33:0] x_q, y_q;
  logic signed [17:0] z_q;
  logic [15:0] heading_q;
  logic [17:0] rem_q;
  logic [30:0] num_q;
  logic [15:0] quo_q;
  logic [33:0] prod_q;
  logic [16:0] min_q;
  logic signed [33:0] px_q, py_q;
  logic signed [15:0] ox_q, oy_q;
  logic [15:0] os_q;
  logic od_q, ovalid_q;

  logic [16:0] slow_eff, divisor;
  logic signed [33:0] dx, dy;
  logic [17:0] tab;
  logic signed [15:0] diff;
  logic [18:0] rem_sh;
  logic signed [33:0] arnd;
  logic [16:0] align;
  logic [16:0] s_new;
  logic [33:0] psum;
  logic signed [33:0] rx, ry;

  // configuration
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 16'd300;
      slow_q <= 16'd1000;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == ovs_pkg::REG_STOP) stop_q <= cfg_i.data;
      if (cfg_i.index == ovs_pkg::REG_SLOW) slow_q <= cfg_i.data;
    end
  end

  // store: write from the front, registered read for the walk
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.ent;
    rd_q <= mem[ovs_pkg::slot_addr(cmd_q.bank, k_q)];
  end

  assign slow_eff = (slow_q > stop_q) ? {1'b0, slow_q} : ({1'b0, stop_q} + 17'd1);
  assign divisor  = slow_eff - {1'b0, stop_q};
  assign dx   = y_q >>> it_q;
  assign dy   = x_q >>> it_q;
  assign tab  = {4'd0, ovs_pkg::atan_entry(it_q)};
  assign diff = $signed(heading_q - rd_q.bearing);
  assign rem_sh = {rem_q, num_q[30]};
  assign arnd = (x_q + 34'sd16384) >>> 15;
  assign align = (arnd < 0) ? 17'd0 :
                 (arnd > 34'sd32768) ? 17'(ovs_pkg::ONE_Q15) : arnd[16:0];
  assign psum  = prod_q + 34'd16384;
  assign s_new = 17'(ovs_pkg::ONE_Q15) - psum[31:15];
  // truncate toward zero
  assign rx = (px_q + (px_q[33] ? 34'sd32767 : 34'sd0)) >>> 15;
  assign ry = (py_q + (py_q[33] ? 34'sd32767 : 34'sd0)) >>> 15;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign stat_o.busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i) begin
        state_d = (q_cmd_i.have && (q_cmd_i.vx != 0 || q_cmd_i.vy != 0)) ? S_HEAD : S_MUL;
      end
      S_HEAD:  if (it_q == ovs_pkg::STEP_W'(ovs_pkg::CORDIC_STEPS - 1)) state_d = S_FETCH;
      S_FETCH: state_d = S_CHECK;
      S_CHECK: begin
        if (!rd_q.finite || ({1'b0, rd_q.range} >= slow_eff) ||
            diff >= 16'sd16384 || diff <= -16'sd16384) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_ITER;
        end
      end
      S_ITER:  if (it_q == ovs_pkg::STEP_W'(ovs_pkg::DIV_STEPS - 1)) state_d = S_ALIGN;
      S_ALIGN: state_d = (align == '0) ? S_NEXT : S_SCALE;
      S_SCALE: state_d = S_NEXT;
      S_NEXT:  state_d = (k_q + 1'b1 >= cmd_q.count) ? S_MUL : S_FETCH;
      S_MUL:   state_d = S_ROUND;
      S_ROUND: if (!ovalid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_o.ready) ovalid_q <= 1'b0;
      if (state_q == S_ROUND && (!ovalid_q || out_o.ready)) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= q_cmd_i;
        min_q <= 17'(ovs_pkg::ONE_Q15);
        k_q   <= '0;
        it_q  <= '0;
        if (q_cmd_i.vx < 0) begin
          if (q_cmd_i.vy >= 0) begin
            x_q <= 34'(q_cmd_i.vy) <<< 14;
            y_q <= -(34'(q_cmd_i.vx) <<< 14);
            z_q <= 18'sd16384;
          end else begin
            x_q <= -(34'(q_cmd_i.vy) <<< 14);
            y_q <= 34'(q_cmd_i.vx) <<< 14;
            z_q <= -18'sd16384;
          end
        end else begin
          x_q <= 34'(q_cmd_i.vx) <<< 14;
          y_q <= 34'(q_cmd_i.vy) <<< 14;
          z_q <= '0;
        end
      end
      S_HEAD: begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + $signed(tab);
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - $signed(tab);
        end
        it_q <= it_q + 1'b1;
        if (it_q == ovs_pkg::STEP_W'(ovs_pkg::CORDIC_STEPS - 1)) begin
          heading_q <= (y_q > 0) ? 16'(z_q + $signed(tab)) : 16'(z_q - $signed(tab));
        end
      end
      S_CHECK: begin
        x_q   <= ovs_pkg::COS_GAIN;
        y_q   <= '0;
        z_q   <= 18'(diff);
        it_q  <= '0;
        rem_q <= '0;
        quo_q <= '0;
        num_q <= ({1'b0, rd_q.range} > {1'b0, stop_q}) ?
                 {rd_q.range - stop_q, 15'd0} : '0;
      end
      S_ITER: begin
        if (it_q < ovs_pkg::STEP_W'(ovs_pkg::CORDIC_STEPS)) begin
          if (z_q >= 0) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - $signed(tab);
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + $signed(tab);
          end
        end
        // one quotient bit per cycle
        if (rem_sh >= {2'd0, divisor}) begin
          rem_q <= 18'(rem_sh - {2'd0, divisor});
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= rem_sh[17:0];
          quo_q <= {quo_q[14:0], 1'b0};
        end
        num_q <= {num_q[29:0], 1'b0};
        it_q  <= it_q + 1'b1;
      end
      S_ALIGN: prod_q <= 34'(align) * 34'(17'(ovs_pkg::ONE_Q15) - {1'b0, quo_q});
      S_SCALE: if (s_new < min_q) min_q <= s_new;
      S_NEXT:  k_q <= k_q + 1'b1;
      S_MUL: begin
        px_q <= 34'(cmd_q.vx) * $signed({17'd0, min_q});
        py_q <= 34'(cmd_q.vy) * $signed({17'd0, min_q});
      end
      S_ROUND: if (!ovalid_q || out_o.ready) begin
        ox_q <= rx[15:0];
        oy_q <= ry[15:0];
        os_q <= min_q[15:0];
        od_q <= cmd_q.have;
      end
      default: ;
    endcase
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.scaled_x      = ox_q;
  assign out_o.scaled_y      = oy_q;
  assign out_o.applied_scale = os_q;
  assign out_o.data_present  = od_q;

endmodule

`default_nettype wire
